/* rtl/core/tmpc_pkg.sv */
package tmpc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPEAT_PERIOD    = 2'd0,
    CFG_FAST_PERIOD      = 2'd1,
    CFG_IDLE_LIMIT       = 2'd2,
    CFG_MEASURE_INTERVAL = 2'd3
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [15:0] RepeatPeriodRst    = 16'd21;
  localparam logic [15:0] FastPeriodRst      = 16'd10;
  localparam logic [15:0] IdleLimitRst       = 16'd1000;
  localparam logic [15:0] MeasureIntervalRst = 16'd1000;

  // menu positions
  localparam logic [2:0] MENU_OFFSET = 3'd0;
  localparam logic [2:0] MENU_LOW    = 3'd1;
  localparam logic [2:0] MENU_HIGH   = 3'd2;
  localparam logic [2:0] MENU_SAVE   = 3'd3;
  localparam logic [2:0] MENU_TEMP   = 3'd4;

  // setting limits and reset values
  localparam logic [7:0] OffsetBottom = 8'd0;
  localparam logic [7:0] OffsetTop    = 8'd40;
  localparam logic [7:0] ThreshBottom = 8'd20;
  localparam logic [7:0] ThreshTop    = 8'd80;
  localparam logic [7:0] LowRst       = 8'd20;
  localparam logic [7:0] HighRst      = 8'd60;
  localparam logic [7:0] TextBase     = 8'd200;
  localparam logic [7:0] FastAfter    = 8'd10;

  // display letter codes
  localparam logic [4:0] DIG_S = 5'd5;
  localparam logic [4:0] DIG_T = 5'd10;
  localparam logic [4:0] DIG_O = 5'd11;
  localparam logic [3:0] DIG_ONE = 4'd1;
  localparam logic [3:0] DIG_TWO = 4'd2;
  localparam logic [3:0] DIG_F = 4'd12;
  localparam logic [3:0] DIG_D = 4'd13;

  typedef struct packed {
    logic       tick;
    logic       up_button;
    logic       set_button;
    logic       sample_ready;
    logic [7:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [15:0] repeat_period;
    logic [15:0] fast_repeat_period;
    logic [15:0] menu_idle_limit;
    logic [15:0] measure_interval;
  } cfg_t;

  typedef struct packed {
    logic       pump_on;
    logic [4:0] digit_high;
    logic [3:0] digit_low;
    logic [2:0] menu_position;
    logic       edit_blink;
    logic       dot_enable;
    logic       dot_blink;
    logic       save_strobe;
  } result_t;

  typedef struct packed {
    logic [4:0] tens;
    logic [3:0] ones;
  } digits_t;

  // saturating tick counter increment
  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // split an 8-bit value into tens and ones, reciprocal multiply by 205/2048
  function automatic digits_t split_dec(logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  rem;
    digits_t     d;
    prod   = {8'd0, v} * 16'd205;
    d.tens = prod[15:11];
    rem    = v - ({3'd0, d.tens} * 8'd10);
    d.ones = rem[3:0];
    return d;
  endfunction

  // left text of a menu entry
  function automatic logic [4:0] text_high(logic [1:0] idx);
    logic [4:0] c;
    case (idx)
      2'd0:    c = DIG_O;
      2'd1:    c = DIG_T;
      2'd2:    c = DIG_T;
      default: c = DIG_S;
    endcase
    return c;
  endfunction

  // right text of a menu entry
  function automatic logic [3:0] text_low(logic [1:0] idx);
    logic [3:0] c;
    case (idx)
      2'd0:    c = DIG_F;
      2'd1:    c = DIG_ONE;
      2'd2:    c = DIG_TWO;
      default: c = DIG_D;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/thermostat_menu_pump_controller_unit.sv */
// an accepted item waits in the input register; its result is offered once registered in the result register
// throughput: one item per cycle, one result per item, while the output is not stalled
// a stalled output lets the input stage take one more item, then the input stalls
// reset: menu in temperature view, thresholds 20 and 60, offset and mean 0,
// configuration registers back to 21, 10, 1000, 1000, no item in flight
module thermostat_menu_pump_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tmpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         tick_i,
  input  logic                         up_button_i,
  input  logic                         set_button_i,
  input  logic                         sample_ready_i,
  input  logic [7:0]                   sample_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         pump_on_o,
  output logic [4:0]                   digit_high_o,
  output logic [3:0]                   digit_low_o,
  output logic [2:0]                   menu_position_o,
  output logic                         edit_blink_o,
  output logic                         dot_enable_o,
  output logic                         dot_blink_o,
  output logic                         save_strobe_o
);

  tmpc_pkg::cfg_t    cfg_q;
  tmpc_pkg::item_t   item_q;
  tmpc_pkg::result_t res, res_q;
  logic              s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic              advance, accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_period      <= tmpc_pkg::RepeatPeriodRst;
      cfg_q.fast_repeat_period <= tmpc_pkg::FastPeriodRst;
      cfg_q.menu_idle_limit    <= tmpc_pkg::IdleLimitRst;
      cfg_q.measure_interval   <= tmpc_pkg::MeasureIntervalRst;
    end else if (cfg_we_i) begin
      case (tmpc_pkg::cfg_idx_e'(cfg_idx_i))
        tmpc_pkg::CFG_REPEAT_PERIOD:    cfg_q.repeat_period      <= cfg_wdata_i;
        tmpc_pkg::CFG_FAST_PERIOD:      cfg_q.fast_repeat_period <= cfg_wdata_i;
        tmpc_pkg::CFG_IDLE_LIMIT:       cfg_q.menu_idle_limit    <= cfg_wdata_i;
        tmpc_pkg::CFG_MEASURE_INTERVAL: cfg_q.measure_interval   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  always_comb begin
    advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o  = s1_valid_q && !advance;
    accept      = in_valid_i && !in_stall_o;
    s1_valid_d  = accept || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.tick         <= tick_i;
      item_q.up_button    <= up_button_i;
      item_q.set_button   <= set_button_i;
      item_q.sample_ready <= sample_ready_i;
      item_q.sample_value <= sample_value_i;
    end
  end

  // control pass
  tmpc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pump_on_o       = res_q.pump_on;
  assign digit_high_o    = res_q.digit_high;
  assign digit_low_o     = res_q.digit_low;
  assign menu_position_o = res_q.menu_position;
  assign edit_blink_o    = res_q.edit_blink;
  assign dot_enable_o    = res_q.dot_enable;
  assign dot_blink_o     = res_q.dot_blink;
  assign save_strobe_o   = res_q.save_strobe;

  // a held item in the input stage is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("input stage item lost");

  // a finished result moves on only into a free or draining output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // editing is never flagged from the temperature view
  a_blink_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.edit_blink && res_q.dot_enable))
    else $error("edit blink in temperature view");

endmodule

/* rtl/core/tmpc_engine.sv */
module tmpc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  tmpc_pkg::item_t   item_i,
  input  tmpc_pkg::cfg_t    cfg_i,
  output tmpc_pkg::result_t res_o
);

  logic [7:0]  offset_q, offset_d, low_q, low_d, high_q, high_d, mean_q, mean_d;
  logic [2:0]  menu_q, menu_d;
  logic        edit_q, edit_d, due_q, due_d, fast_q, fast_d;
  logic [15:0] bticks_q, bticks_d, iticks_q, iticks_d, mticks_q, mticks_d;
  logic [7:0]  rcount_q, rcount_d;
  logic [4:0]  shown_high_q, shown_high_d;
  logic [3:0]  shown_low_q, shown_low_d;

  logic [15:0] bt1, it1, mt1, period;
  logic [2:0]  ms0, ms1;
  logic [8:0]  sum, nv, mean_sum;
  logic        stepped, save, pump, blink, dot, ed1;
  logic [7:0]  cur, lim_top, lim_bot, mean_diff;
  tmpc_pkg::digits_t dig;

  // next state for one pass
  always_comb begin
    offset_d     = offset_q;
    low_d        = low_q;
    high_d       = high_q;
    mean_d       = mean_q;
    edit_d       = edit_q;
    rcount_d     = rcount_q;
    fast_d       = fast_q;
    shown_high_d = shown_high_q;
    shown_low_d  = shown_low_q;
    stepped      = 1'b0;
    save         = 1'b0;
    blink        = 1'b0;
    ms1          = tmpc_pkg::MENU_TEMP;
    nv           = 9'd0;
    mean_sum     = {1'b0, mean_q} + {1'b0, item_i.sample_value};
    mean_diff    = mean_d - tmpc_pkg::TextBase;
    dig          = tmpc_pkg::split_dec(8'd0);

    // timer tick
    bt1 = item_i.tick ? tmpc_pkg::sat_inc16(bticks_q) : bticks_q;
    it1 = item_i.tick ? tmpc_pkg::sat_inc16(iticks_q) : iticks_q;
    mt1 = item_i.tick ? tmpc_pkg::sat_inc16(mticks_q) : mticks_q;

    // idle return to temperature view
    ms0 = (it1 >= cfg_i.menu_idle_limit) ? tmpc_pkg::MENU_TEMP : menu_q;
    if (ms0 > tmpc_pkg::MENU_TEMP) begin
      ms0 = tmpc_pkg::MENU_OFFSET;
    end

    // pump window
    sum  = {1'b0, offset_q} + {1'b0, mean_q};
    pump = (sum > {1'b0, low_q}) && (sum < {1'b0, high_q});

    // up button with auto-repeat
    bticks_d = bt1;
    period   = fast_q ? cfg_i.fast_repeat_period : cfg_i.repeat_period;
    if (item_i.up_button) begin
      if (bt1 >= period) begin
        bticks_d = 16'd0;
        stepped  = 1'b1;
        if (rcount_q != 8'hFF) begin
          rcount_d = rcount_q + 8'd1;
        end
        fast_d = rcount_d > tmpc_pkg::FastAfter;
      end
    end else begin
      fast_d   = 1'b0;
      rcount_d = 8'd0;
    end

    // set button toggles editing
    period = fast_d ? cfg_i.fast_repeat_period : cfg_i.repeat_period;
    ed1    = edit_q;
    if (item_i.set_button && (bticks_d >= period)) begin
      bticks_d = 16'd0;
      ed1      = !edit_q;
    end

    iticks_d = stepped ? 16'd0 : it1;
    dot      = (ms0 == tmpc_pkg::MENU_TEMP);
    if (dot) begin
      ed1 = 1'b0;
    end
    edit_d = ed1;

    // setting under edit
    case (ms0)
      tmpc_pkg::MENU_OFFSET: cur = offset_q;
      tmpc_pkg::MENU_LOW:    cur = low_q;
      default:               cur = high_q;
    endcase
    lim_top = (ms0 == tmpc_pkg::MENU_OFFSET) ? tmpc_pkg::OffsetTop : tmpc_pkg::ThreshTop;
    lim_bot = (ms0 == tmpc_pkg::MENU_OFFSET) ? tmpc_pkg::OffsetBottom
                                             : tmpc_pkg::ThreshBottom;

    // menu
    if (ed1) begin
      blink = 1'b1;
      if (ms0 == tmpc_pkg::MENU_SAVE) begin
        edit_d = 1'b0;
        save   = 1'b1;
        ms1    = tmpc_pkg::MENU_TEMP;
      end else begin
        ms1 = ms0;
        nv  = {1'b0, cur} + {8'd0, stepped};
        if (nv > {1'b0, lim_top}) begin
          nv = {1'b0, lim_bot};
        end
        case (ms0)
          tmpc_pkg::MENU_OFFSET: offset_d = nv[7:0];
          tmpc_pkg::MENU_LOW:    low_d    = nv[7:0];
          default:               high_d   = nv[7:0];
        endcase
        dig          = tmpc_pkg::split_dec(nv[7:0]);
        shown_high_d = dig.tens;
        shown_low_d  = dig.ones;
      end
    end else begin
      ms1 = stepped ? ms0 + 3'd1 : ms0;
      if (ms1 > tmpc_pkg::MENU_TEMP) begin
        ms1 = tmpc_pkg::MENU_OFFSET;
      end
      if (ms1 != tmpc_pkg::MENU_TEMP) begin
        shown_high_d = tmpc_pkg::text_high(ms1[1:0]);
        shown_low_d  = tmpc_pkg::text_low(ms1[1:0]);
      end else begin
        // running mean of accepted samples
        if (due_q && item_i.sample_ready) begin
          mean_d = (mean_q != 8'd0) ? mean_sum[8:1] : item_i.sample_value;
        end
        mean_diff = mean_d - tmpc_pkg::TextBase;
        if (mean_d < tmpc_pkg::TextBase) begin
          dig          = tmpc_pkg::split_dec(mean_d);
          shown_high_d = dig.tens;
          shown_low_d  = dig.ones;
        end else if (mean_diff < 8'd4) begin
          shown_high_d = tmpc_pkg::text_high(mean_diff[1:0]);
          shown_low_d  = tmpc_pkg::text_low(mean_diff[1:0]);
        end
      end
    end
    menu_d = ms1;

    // measurement scheduling
    mticks_d = mt1;
    due_d    = (!ed1 && (ms1 == tmpc_pkg::MENU_TEMP) && due_q && item_i.sample_ready)
               ? 1'b0 : due_q;
    if (mt1 >= cfg_i.measure_interval) begin
      mticks_d = 16'd0;
      due_d    = 1'b1;
    end

    res_o.pump_on       = pump;
    res_o.digit_high    = shown_high_d;
    res_o.digit_low     = shown_low_d;
    res_o.menu_position = menu_d;
    res_o.edit_blink    = blink;
    res_o.dot_enable    = dot;
    res_o.dot_blink     = pump;
    res_o.save_strobe   = save;
  end

  // state registers, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= tmpc_pkg::OffsetBottom;
      low_q        <= tmpc_pkg::LowRst;
      high_q       <= tmpc_pkg::HighRst;
      mean_q       <= 8'd0;
      menu_q       <= tmpc_pkg::MENU_TEMP;
      edit_q       <= 1'b0;
      bticks_q     <= 16'd0;
      iticks_q     <= 16'd0;
      mticks_q     <= 16'd0;
      due_q        <= 1'b1;
      rcount_q     <= 8'd0;
      fast_q       <= 1'b0;
      shown_high_q <= 5'd0;
      shown_low_q  <= 4'd0;
    end else if (step_i) begin
      offset_q     <= offset_d;
      low_q        <= low_d;
      high_q       <= high_d;
      mean_q       <= mean_d;
      menu_q       <= menu_d;
      edit_q       <= edit_d;
      bticks_q     <= bticks_d;
      iticks_q     <= iticks_d;
      mticks_q     <= mticks_d;
      due_q        <= due_d;
      rcount_q     <= rcount_d;
      fast_q       <= fast_d;
      shown_high_q <= shown_high_d;
      shown_low_q  <= shown_low_d;
    end
  end

  // settings stay inside their wrap ranges
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= tmpc_pkg::OffsetTop)
    else $error("offset setting out of range");

  a_thresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q >= tmpc_pkg::ThreshBottom) && (low_q <= tmpc_pkg::ThreshTop) &&
    (high_q >= tmpc_pkg::ThreshBottom) && (high_q <= tmpc_pkg::ThreshTop))
    else $error("threshold out of range");

  // menu never leaves its five positions
  a_menu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    menu_q <= tmpc_pkg::MENU_TEMP)
    else $error("menu position out of range");

  // a save always returns to the temperature view and ends editing
  a_save_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.save_strobe) |=> (menu_q == tmpc_pkg::MENU_TEMP) && !edit_q)
    else $error("save did not leave edit mode");

endmodule
